>>> design/krnb_pkg.sv
// Package for the nearest-bucket ring lookup block.
// Holds the transfer payload types, command and status codes, and the sequencer states.
// Has no dependencies; the top level and the checker import it.
`default_nettype none

package krnb_pkg;

    // Command codes carried in the input transfer.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Status codes carried in the output transfer.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_DUP   = 2'd3;

    // Width of a ring position and of a bucket identifier.
    localparam int unsigned RING_W = 64;

    typedef struct packed {
        logic [1:0]        command;
        logic [RING_W-1:0] key_word0;
        logic [RING_W-1:0] key_word1;
        logic [RING_W-1:0] key_word2;
        logic [RING_W-1:0] key_word3;
        logic [RING_W-1:0] bucket_id_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [RING_W-1:0] bucket_id_out;
        logic [RING_W-1:0] ring_position;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUP_SCAN,
        ST_PASS1,
        ST_PASS2,
        ST_PICK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> design/key_to_ring_nearest_bucket.sv
// Top level of the nearest-bucket ring lookup block.
// Depends on krnb_pkg and instantiates krnb_ram for the bucket table.
//
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one command per
// transfer: clear, insert a bucket identifier, or look up a 256-bit key.
// The output channel (out_valid, out_ready, out_data) returns exactly one
// result per command, in order.
// The bucket table is a single-port RAM holding up to MAX_BUCKETS entries;
// a single compare unit walks it one entry per cycle, so its one port sets
// the timing. With N stored entries:
//   clear, unused codes and lookup on an empty table: no scan; the result
//   is formed directly.
//   insert: one duplicate scan of the N entries, then the write.
//   lookup: a pass for the right neighbor, smallest and largest entries,
//   then a pass for the left neighbor, then a pick.
// One command is in flight at a time; in_ready is high only while idle.
// A result waits in the output register while out_ready is low; the block
// may accept the next command meanwhile but holds its result until the
// register is free.
// Reset empties the table by clearing the entry count; no clearing pass
// runs, and the block is ready in the first cycle after reset.
`default_nettype none

module key_to_ring_nearest_bucket #(
    parameter int unsigned MAX_BUCKETS = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire krnb_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output krnb_pkg::out_item_t      out_data
);

    import krnb_pkg::*;

    localparam int unsigned ADDR_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_BUCKETS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUCKETS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [RING_W-1:0] pos_reg, pos_next;
    logic [RING_W-1:0] id_reg, id_next;
    logic [RING_W-1:0] lo_reg, lo_next;
    logic [RING_W-1:0] hi_reg, hi_next;
    logic [RING_W-1:0] right_reg, right_next;
    logic [RING_W-1:0] left_reg, left_next;
    logic              have_right_reg, have_right_next;
    logic              have_left_reg, have_left_next;
    logic              dup_reg, dup_next;
    logic [RING_W-1:0] dist_r_reg, dist_r_next;
    logic [RING_W-1:0] dist_l_reg, dist_l_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;

    logic              in_xfer;
    logic              scanning;
    logic              scan_issue;
    logic              scan_done;
    logic              out_free;
    logic              can_write;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [RING_W-1:0] ram_rdata;
    logic [RING_W-1:0] left_final;
    out_item_t         result;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Scan control shared by the duplicate check and both lookup passes.
    assign scanning   = (state_reg == ST_DUP_SCAN) || (state_reg == ST_PASS1)
                        || (state_reg == ST_PASS2);
    assign scan_issue = scanning && (idx_reg < count_reg);
    assign scan_done  = scanning && (idx_reg == count_reg) && !rd_vld_reg;

    // An insert writes only when it is new and the table has room.
    assign can_write = (cmd_reg == CMD_INSERT) && !dup_reg && (count_reg != CNT_MAX);

    // RAM port: the write slot at completion, reads during a scan.
    always_comb
    begin
        ram_we   = (state_reg == ST_DONE) && out_free && can_write;
        ram_addr = ram_we ? count_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    end

    krnb_ram #(
        .WIDTH  (RING_W),
        .DEPTH  (MAX_BUCKETS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (scan_issue),
        .addr  (ram_addr),
        .wdata (id_reg),
        .rdata (ram_rdata)
    );

    // Result of the finished command.
    always_comb
    begin
        result = '0;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (dup_reg)
                begin
                    result.status = STAT_DUP;
                end
                else if (count_reg == CNT_MAX)
                begin
                    result.status = STAT_FULL;
                end
                else
                begin
                    result.status = STAT_OK;
                end
            end
            CMD_LOOKUP:
            begin
                result.ring_position = pos_reg;
                if (count_reg == '0)
                begin
                    result.status = STAT_EMPTY;
                end
                else
                begin
                    result.bucket_id_out = (dist_r_reg < dist_l_reg) ? right_reg : left_reg;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.command == CMD_INSERT)
                    begin
                        state_next = ST_DUP_SCAN;
                    end
                    else if ((in_data.command == CMD_LOOKUP) && (count_reg != '0))
                    begin
                        state_next = ST_PASS1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DUP_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PASS1:
            begin
                if (scan_done)
                begin
                    state_next = ST_PASS2;
                end
            end
            ST_PASS2:
            begin
                if (scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign left_final = have_left_reg ? left_reg : hi_reg;

    // Datapath and output register updates.
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        rd_vld_next     = scan_issue;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        id_next         = id_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        have_right_next = have_right_reg;
        have_left_next  = have_left_reg;
        dup_next        = dup_reg;
        dist_r_next     = dist_r_reg;
        dist_l_next     = dist_l_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (scan_issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next        = in_data.command;
                    id_next         = in_data.bucket_id_in;
                    pos_next        = in_data.key_word0 ^ in_data.key_word1
                                      ^ in_data.key_word2 ^ in_data.key_word3;
                    idx_next        = '0;
                    dup_next        = 1'b0;
                    lo_next         = '1;
                    hi_next         = '0;
                    have_right_next = 1'b0;
                    if (in_data.command == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_DUP_SCAN:
            begin
                if (rd_vld_reg && (ram_rdata == id_reg))
                begin
                    dup_next = 1'b1;
                end
            end
            ST_PASS1:
            begin
                if (rd_vld_reg)
                begin
                    if (ram_rdata < lo_reg)
                    begin
                        lo_next = ram_rdata;
                    end
                    if (ram_rdata > hi_reg)
                    begin
                        hi_next = ram_rdata;
                    end
                    if ((ram_rdata >= pos_reg) && (!have_right_reg || (ram_rdata < right_reg)))
                    begin
                        right_next      = ram_rdata;
                        have_right_next = 1'b1;
                    end
                end
                if (scan_done)
                begin
                    // Wrap to the smallest entry when none lies at or above the position.
                    right_next     = have_right_reg ? right_reg : lo_reg;
                    idx_next       = '0;
                    have_left_next = 1'b0;
                end
            end
            ST_PASS2:
            begin
                if (rd_vld_reg && (ram_rdata < right_reg)
                    && (!have_left_reg || (ram_rdata > left_reg)))
                begin
                    left_next      = ram_rdata;
                    have_left_next = 1'b1;
                end
            end
            ST_PICK:
            begin
                // Wrap the left neighbor to the largest entry, then form both distances.
                left_next   = left_final;
                dist_r_next = right_reg - pos_reg;
                dist_l_next = pos_reg - left_final;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_next       = result;
                    out_valid_next = 1'b1;
                    if (can_write)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                rd_vld_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        id_reg         <= id_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        right_reg      <= right_next;
        left_reg       <= left_next;
        have_right_reg <= have_right_next;
        have_left_reg  <= have_left_next;
        dup_reg        <= dup_next;
        dist_r_reg     <= dist_r_next;
        dist_l_reg     <= dist_l_next;
        res_reg        <= res_next;
    end

endmodule

`default_nettype wire

>>> design/krnb_ram.sv
// Generic single-port RAM with a registered read.
// Used for the bucket table; no dependencies.
`default_nettype none

module krnb_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One access per cycle: a write or a registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else if (re)
        begin
            rdata <= mem_reg[addr];
        end
    end

endmodule

`default_nettype wire

>>> design/krnb_checker.sv
// Port-level checker for the nearest-bucket ring lookup block.
// Depends on krnb_pkg; bound to key_to_ring_nearest_bucket below.
`default_nettype none

module krnb_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire krnb_pkg::out_item_t out_data
);

    import krnb_pkg::*;

    // A stalled result holds its value until the transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output result changed while stalled");

    // Every command leaves the idle state, so the input closes after a transfer.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again in the cycle after a transfer");

    // Only a successful lookup names a bucket.
    a_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != STAT_OK) |-> out_data.bucket_id_out == '0)
        else $error("bucket identifier reported with a failing status");

    // Failing insert outcomes (full, duplicate) carry no ring position.
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_data.status == STAT_FULL) || (out_data.status == STAT_DUP))
        |-> out_data.ring_position == '0)
        else $error("ring position reported on an insert result");

endmodule

bind key_to_ring_nearest_bucket krnb_checker u_krnb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
